/* hdl/subpicture_rle_run_decoder_assert.svh */
// Assertion macros used by the subpicture run decoder result queue.
`ifndef SUBPICTURE_RLE_RUN_DECODER_ASSERT_SVH
`define SUBPICTURE_RLE_RUN_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define RLERD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rlerd assertion failed");
`define RLERD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlerd assertion failed");
`define RLERD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlerd assertion failed");
`else
`define RLERD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define RLERD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RLERD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/rlerd_pkg.sv */
// Types and constants shared by the subpicture run decoder modules.
`default_nettype none
package rlerd_pkg;

   localparam int MAX_DIM   = 2048;
   localparam int DIM_W     = 12;
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 16;
   localparam int CODE_W    = 16;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int RUN_XY_W  = 11;
   localparam int CLUT_W    = 4;
   localparam int ALPHA_W   = 8;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH) + 1;

   localparam logic [DIM_W-1:0]  WIDTH_RST   = DIM_W'(720);
   localparam logic [DIM_W-1:0]  HEIGHT_RST  = DIM_W'(575);
   localparam logic [POS_W-1:0]  ODD_RST     = '0;
   localparam logic [15:0]       PALETTE_RST = 16'h3210;
   localparam logic [CSR_W-1:0]  ALPHA_RST   = 32'hFFFF_FFFF;

   localparam logic [CODE_W-1:0] CODE_MIN_1  = 16'h0004;
   localparam logic [CODE_W-1:0] CODE_MIN_2  = 16'h0010;
   localparam logic [CODE_W-1:0] CODE_MIN_3  = 16'h0040;
   localparam logic [POS_W-1:0]  FIELD_LEAD  = 16'd4;
   localparam logic [POS_W-1:0]  POS_MAX     = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_FIELD_START,
      CSR_PALETTE,
      CSR_ALPHA
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [POS_W-1:0] field_start;
      logic [15:0]      palette;
      logic [CSR_W-1:0] alpha;
   } cfg_type;

   typedef struct packed {
      logic [RUN_XY_W-1:0] run_x;
      logic [RUN_XY_W-1:0] run_y;
      logic [DIM_W-1:0]    run_length;
      logic [CLUT_W-1:0]   clut_index;
      logic [ALPHA_W-1:0]  run_alpha;
      logic                run_last;
   } run_type;

   typedef struct packed {
      logic [1:0] n;
      run_type    first;
      run_type    second;
   } qpush_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIM_W-1:0] value;
   } rowmod_type;

endpackage
`default_nettype wire

/* hdl/rlerd_ifs.sv */
// Valid/ready channel interfaces for pixel bytes and decoded runs.
`default_nettype none
interface rlerd_req_if;
   import rlerd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_byte;
   logic              last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface rlerd_rsp_if;
   import rlerd_pkg::*;

   logic                valid;
   logic                ready;
   logic [RUN_XY_W-1:0] run_x;
   logic [RUN_XY_W-1:0] run_y;
   logic [DIM_W-1:0]    run_length;
   logic [CLUT_W-1:0]   clut_index;
   logic [ALPHA_W-1:0]  run_alpha;
   logic                run_last;

   modport source (output valid, run_x, run_y, run_length, clut_index, run_alpha, run_last,
                   input ready);
   modport sink   (input valid, run_x, run_y, run_length, clut_index, run_alpha, run_last,
                   output ready);
endinterface
`default_nettype wire

/* hdl/rlerd_csr.sv */
// Configuration registers with clamping of the picture dimensions.
`default_nettype none
module rlerd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [rlerd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rlerd_pkg::CSR_W-1:0]     csr_wdata,
   output rlerd_pkg::cfg_type                   cfg,
   output logic                                 height_written
);
   import rlerd_pkg::*;

   cfg_type cfg_ff;
   logic    hwr_ff;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if ({1'b0, v} > (DIM_W+1)'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width       <= WIDTH_RST;
         cfg_ff.height      <= HEIGHT_RST;
         cfg_ff.field_start <= ODD_RST;
         cfg_ff.palette     <= PALETTE_RST;
         cfg_ff.alpha       <= ALPHA_RST;
         hwr_ff             <= 1'b0;
      end else begin
         hwr_ff <= csr_we && (csr_index == CSR_HEIGHT);
         if (csr_we) begin
            case (csr_index)
               CSR_WIDTH:       cfg_ff.width       <= clamp_dim(csr_wdata[DIM_W-1:0]);
               CSR_HEIGHT:      cfg_ff.height      <= clamp_dim(csr_wdata[DIM_W-1:0]);
               CSR_FIELD_START: cfg_ff.field_start <= csr_wdata[POS_W-1:0];
               CSR_PALETTE:     cfg_ff.palette     <= csr_wdata[15:0];
               CSR_ALPHA:       cfg_ff.alpha       <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign cfg            = cfg_ff;
   assign height_written = hwr_ff;
endmodule
`default_nettype wire

/* hdl/rlerd_rowmod.sv */
// Bit-serial remainder of the current row by a newly written picture height.
`default_nettype none
module rlerd_rowmod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rlerd_pkg::DIM_W-1:0] row,
   input  wire logic [rlerd_pkg::DIM_W-1:0] height,
   output rlerd_pkg::rowmod_type            rmod
);
   import rlerd_pkg::*;

   localparam int CNT_W = $clog2(DIM_W);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIM_W-1:0] rem_ff;
   logic [DIM_W-1:0] sh_ff;
   logic [DIM_W-1:0] trial;
   logic [DIM_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff[DIM_W-2:0], sh_ff[DIM_W-1]};
      rem_in = (trial >= height) ? trial - height : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         sh_ff  <= row;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= {sh_ff[DIM_W-2:0], 1'b0};
      end
   end

   assign rmod.busy  = start || run_ff;
   assign rmod.done  = done_ff;
   assign rmod.value = rem_ff;
endmodule
`default_nettype wire

/* hdl/rlerd_decode.sv */
// Input register and single-pass decode of both nibbles of a pixel byte.
`default_nettype none
module rlerd_decode (
   input  wire logic                        clock,
   input  wire logic                        reset,
   rlerd_req_if.sink                        req_if,
   input  wire rlerd_pkg::cfg_type          cfg,
   input  wire rlerd_pkg::rowmod_type       rmod,
   input  wire logic                        q_room,
   output logic [rlerd_pkg::DIM_W-1:0]      row,
   output rlerd_pkg::qpush_type             push
);
   import rlerd_pkg::*;

   typedef struct packed {
      logic [DIM_W-1:0]  column;
      logic [DIM_W-1:0]  row;
      logic [DIM_W-1:0]  rowmod;
      logic              odd;
      logic [CODE_W-1:0] acc;
      logic [2:0]        nheld;
      logic [3:0]        transp;
      logic              await_first;
   } dstate_type;

   typedef struct packed {
      dstate_type st;
      logic       emit;
      run_type    run;
      logic       eol;
   } step_type;

   localparam dstate_type RESTART = '{column: '0, row: '0, rowmod: '0, odd: 1'b0, acc: '0,
                                      nheld: '0, transp: '0, await_first: 1'b1};

   function automatic step_type nibble_step(dstate_type s, logic [3:0] nib, logic is_low,
                                            logic at_end, logic field_due, cfg_type c);
      step_type          r;
      logic              switch_now;
      logic              done;
      logic [DIM_W-1:0]  avail;
      logic [DIM_W-1:0]  len;
      logic [DIM_W-1:0]  col_sum;
      logic [CODE_W-3:0] code_len;
      logic [1:0]        colour;
      logic [DIM_W:0]    row2;
      logic [DIM_W:0]    t;
      logic [DIM_W-1:0]  wrapped;
      r      = '0;
      r.st   = s;
      done   = 1'b0;
      avail  = '0;
      len    = '0;
      col_sum = '0;
      code_len = '0;
      colour = '0;
      row2   = '0;
      t      = '0;
      wrapped = '0;
      switch_now = (s.nheld == 3'd0) && !s.odd && field_due;
      if (switch_now) begin
         r.st.odd    = 1'b1;
         r.st.column = '0;
      end
      if (!(switch_now && is_low)) begin
         r.st.acc   = {s.acc[CODE_W-5:0], nib};
         r.st.nheld = s.nheld + 3'd1;
         case (r.st.nheld)
            3'd1:    done = r.st.acc >= CODE_MIN_1;
            3'd2:    done = r.st.acc >= CODE_MIN_2;
            3'd3:    done = r.st.acc >= CODE_MIN_3;
            default: done = 1'b1;
         endcase
         done = done || at_end;
         if (done) begin
            avail    = (r.st.column < c.width) ? c.width - r.st.column : '0;
            code_len = r.st.acc[CODE_W-1:2];
            if (r.st.nheld >= 3'd4 && r.st.acc < CODE_MIN_1 && !at_end) begin
               len = avail;
            end else if (code_len > (CODE_W-2)'(avail)) begin
               len = avail;
            end else begin
               len = code_len[DIM_W-1:0];
            end
            colour = r.st.acc[1:0];
            if (r.st.await_first) begin
               r.st.transp[colour] = 1'b1;
               r.st.await_first    = 1'b0;
            end
            r.emit             = ({1'b0, r.st.row} + (DIM_W+1)'(1)) < {1'b0, c.height};
            r.run.run_x        = r.st.column[RUN_XY_W-1:0];
            r.run.run_y        = r.st.row[RUN_XY_W-1:0];
            r.run.run_length   = len;
            r.run.clut_index   = c.palette[{colour, 2'b00} +: CLUT_W];
            r.run.run_alpha    = r.st.transp[colour] ? '0
                                                     : c.alpha[{colour, 3'b000} +: ALPHA_W];
            r.run.run_last     = 1'b0;
            col_sum            = r.st.column + len;
            r.st.column        = col_sum;
            r.st.acc           = '0;
            r.st.nheld         = '0;
            if (col_sum >= c.width) begin
               r.eol       = 1'b1;
               r.st.column = '0;
               row2        = {1'b0, r.st.row} + (DIM_W+1)'(2);
               if (row2 >= {1'b0, c.height}) begin
                  t = {1'b0, r.st.rowmod} + (DIM_W+1)'(3);
                  if (c.height == DIM_W'(1)) begin
                     wrapped = '0;
                  end else if (c.height == DIM_W'(2)) begin
                     wrapped = {{(DIM_W-1){1'b0}}, t[0]};
                  end else if (t >= {1'b0, c.height}) begin
                     wrapped = DIM_W'(t - {1'b0, c.height});
                  end else begin
                     wrapped = t[DIM_W-1:0];
                  end
                  r.st.row    = wrapped;
                  r.st.rowmod = wrapped;
               end else begin
                  r.st.row    = row2[DIM_W-1:0];
                  r.st.rowmod = row2[DIM_W-1:0];
               end
            end
         end
      end
      return r;
   endfunction

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_data_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   dstate_type        st_ff;
   dstate_type        st_in;
   logic [POS_W-1:0]  bpos_ff;
   logic [POS_W-1:0]  bpos_in;
   dstate_type        base;
   logic [POS_W-1:0]  base_bpos;
   logic              field_due;
   logic              fire;
   logic              run_low;
   logic              lo_emit;
   step_type          hi;
   step_type          lo;

   assign fire         = in_valid_ff && q_room;
   assign req_if.ready = !rmod.busy && (!in_valid_ff || fire);

   always_comb begin
      base      = in_first_ff ? RESTART : st_ff;
      base_bpos = in_first_ff ? '0 : bpos_ff;
      field_due = ({1'b0, base_bpos} + {1'b0, FIELD_LEAD}) >= {1'b0, cfg.field_start};
      hi        = nibble_step(base, in_data_ff[7:4], 1'b0, 1'b0, field_due, cfg);
      run_low   = !hi.eol;
      lo        = nibble_step(hi.st, in_data_ff[3:0], 1'b1, in_last_ff, field_due, cfg);
      lo_emit   = run_low && lo.emit;
      st_in     = run_low ? lo.st : hi.st;
      bpos_in   = (base_bpos == POS_MAX) ? base_bpos : base_bpos + POS_W'(1);
      if (in_last_ff) begin
         st_in   = RESTART;
         bpos_in = '0;
      end

      push.first           = hi.emit ? hi.run : lo.run;
      push.first.run_last  = !(hi.emit && lo_emit);
      push.second          = lo.run;
      push.second.run_last = 1'b1;
      push.n               = fire ? 2'({1'b0, hi.emit} + {1'b0, lo_emit}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= RESTART;
         bpos_ff     <= '0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (rmod.done) begin
            st_ff.rowmod <= rmod.value;
         end else if (fire) begin
            st_ff   <= st_in;
            bpos_ff <= bpos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_data_ff  <= req_if.data_byte;
         in_first_ff <= req_if.first_byte;
         in_last_ff  <= req_if.last_byte;
      end
   end

   assign row = st_ff.row;
endmodule
`default_nettype wire

/* hdl/rlerd_outq.sv */
// Four-entry result queue taking up to two runs a cycle while two entries are free, and releasing one.
`default_nettype none
`include "subpicture_rle_run_decoder_assert.svh"
module rlerd_outq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rlerd_pkg::qpush_type push,
   rlerd_rsp_if.source               rsp_if,
   output logic                      q_room
);
   import rlerd_pkg::*;

   run_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff;
   logic [Q_PTR_W-1:0] rd_ff;
   logic [Q_CNT_W-1:0] cnt_ff;
   logic               pop;
   run_type            head;

   assign pop    = rsp_if.valid && rsp_if.ready;
   assign q_room = cnt_ff <= Q_CNT_W'(Q_DEPTH - 2);
   assign head   = mem_ff[rd_ff];

   assign rsp_if.valid      = cnt_ff != '0;
   assign rsp_if.run_x      = head.run_x;
   assign rsp_if.run_y      = head.run_y;
   assign rsp_if.run_length = head.run_length;
   assign rsp_if.clut_index = head.clut_index;
   assign rsp_if.run_alpha  = head.run_alpha;
   assign rsp_if.run_last   = head.run_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + Q_PTR_W'(push.n);
         rd_ff  <= rd_ff + Q_PTR_W'(pop);
         cnt_ff <= cnt_ff + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_ff + Q_PTR_W'(1)] <= push.second;
      end
   end

   `RLERD_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= Q_CNT_W'(Q_DEPTH))
   `RLERD_ASSERT_ALWAYS(a_ptr_match, clock, reset, (wr_ff - rd_ff) == cnt_ff[Q_PTR_W-1:0])
   `RLERD_ASSERT_IMPL(a_push_room, clock, reset, push.n != 2'd0, q_room)
   `RLERD_ASSERT_NEXT(a_drain, clock, reset, cnt_ff == Q_CNT_W'(1) && pop && push.n == 2'd0, !rsp_if.valid)
endmodule
`default_nettype wire

/* hdl/subpicture_rle_run_decoder.sv */
// Top level of the subpicture run-length run decoder.
// Usage:
//   req_if carries one pixel-data byte per transfer with first_byte and
//   last_byte packet marks; rsp_if carries the decoded runs (x, y, length,
//   CLUT index, alpha, last-of-byte mark). Each byte gives zero to two runs.
//   The csr_ port writes image_width, image_height, odd_field_offset,
//   palette_map and alpha_table by index; write only while no byte is in flight.
//   A byte taken is held in the input register, decoded, and its runs are
//   written into the four-entry result queue, whose head drives rsp_if;
//   a second run follows the first. Bytes are taken one per cycle when each
//   gives at most one run and rsp_if is ready; when every byte gives two
//   runs, the single output transfer per cycle of the queue sets the rate.
//   A write of image_height holds req_if.ready low while a bit-serial unit
//   reduces the current row modulo the new height.
//   Reset restores the register defaults and the packet-start state and
//   empties the queue. When rsp_if stalls, the queue fills and req_if.ready
//   drops; nothing is lost.
`default_nettype none
module subpicture_rle_run_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rlerd_req_if.sink                            req_if,
   rlerd_rsp_if.source                          rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [rlerd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rlerd_pkg::CSR_W-1:0]     csr_wdata
);
   import rlerd_pkg::*;

   cfg_type          cfg;
   logic             height_written;
   rowmod_type       rmod;
   logic [DIM_W-1:0] row;
   qpush_type        push;
   logic             q_room;

   rlerd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cfg            (cfg),
      .height_written (height_written)
   );

   rlerd_rowmod u_rowmod (
      .clock  (clock),
      .reset  (reset),
      .start  (height_written),
      .row    (row),
      .height (cfg.height),
      .rmod   (rmod)
   );

   rlerd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg),
      .rmod   (rmod),
      .q_room (q_room),
      .row    (row),
      .push   (push)
   );

   rlerd_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_if (rsp_if),
      .q_room (q_room)
   );
endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for the subpicture run decoder: table and random bytes against a predictor.
module tb;
   import rlerd_pkg::*;

   localparam int CSR_COUNT   = 5;
   localparam int PHASES      = 12;
   localparam int PHASE_BYTES = 70;
   localparam int LONG_BYTES  = 120;
   localparam int LONG_FIELD  = 100;
   localparam int IDLE_PCT    = 27;
   localparam int HOLD_CYCLES = 250;
   localparam int HOLD_AFTER  = 300;
   localparam int LIMIT       = 100000;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [BYTE_W-1:0]    data;
      logic                 first;
      logic                 last;
      logic                 typed;
      logic [1:0]           n_runs;
      run_type              run_a;
      run_type              run_b;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CSR_W-1:0]     csr_value;
   } plan_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   rlerd_req_if req_bus ();
   rlerd_rsp_if rsp_bus ();

   subpicture_rle_run_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [DIM_W-1:0] cfg_width   = WIDTH_RST;
   logic [DIM_W-1:0] cfg_height  = HEIGHT_RST;
   logic [POS_W-1:0] cfg_odd     = ODD_RST;
   logic [15:0]      cfg_palette = PALETTE_RST;
   logic [CSR_W-1:0] cfg_alpha   = ALPHA_RST;

   int unsigned col;
   int unsigned row_at;
   bit          odd_active;
   logic [15:0] code;
   int          held;
   int unsigned pos;
   logic [3:0]  see_through;
   bit          first_pending;

   run_type expected_runs[$];
   int      failures       = 0;
   int      cycles         = 0;
   int      bytes_accepted = 0;
   bit      calm           = 1'b0;

   function automatic void restart_packet();
      col = 0;
      row_at = 0;
      odd_active = 1'b0;
      code = '0;
      held = 0;
      pos = 0;
      see_through = '0;
      first_pending = 1'b1;
   endfunction

   function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      case (idx)
         CSR_WIDTH:       cfg_width   = value[DIM_W-1:0];
         CSR_HEIGHT:      cfg_height  = value[DIM_W-1:0];
         CSR_FIELD_START: cfg_odd     = value[POS_W-1:0];
         CSR_PALETTE:     cfg_palette = value[15:0];
         CSR_ALPHA:       cfg_alpha   = value;
         default: ;
      endcase
   endfunction

   task automatic decode_pixel_byte(input logic [BYTE_W-1:0] data, input logic first,
                                    input logic last, input bit publish);
      int unsigned w;
      int unsigned h;
      int unsigned avail;
      int unsigned len;
      logic [3:0]  nib;
      logic [1:0]  colour;
      bit          at_end;
      bit          done;
      bit          skip_low;
      run_type     made [2];
      int          made_n;
      made_n = 0;
      skip_low = 1'b0;
      if (first) restart_packet();
      w = dim_in_use(cfg_width);
      h = dim_in_use(cfg_height);
      for (int half = 0; half < 2; half++) begin
         if (half == 1 && skip_low) break;
         nib = (half == 0) ? data[7:4] : data[3:0];
         at_end = last && half == 1;
         if (held == 0 && !odd_active && pos + 4 >= cfg_odd) begin
            odd_active = 1'b1;
            col = 0;
            if (half == 1) break;
         end
         code = {code[11:0], nib};
         held++;
         case (held)
            1:       done = code >= CODE_MIN_1;
            2:       done = code >= CODE_MIN_2;
            3:       done = code >= CODE_MIN_3;
            default: done = 1'b1;
         endcase
         if (at_end) done = 1'b1;
         if (!done) continue;
         avail = (col < w) ? w - col : 0;
         len = code >> 2;
         if (held >= 4 && code < CODE_MIN_1 && !at_end) len = avail;
         if (len > avail) len = avail;
         colour = code[1:0];
         if (first_pending) begin
            see_through[colour] = 1'b1;
            first_pending = 1'b0;
         end
         if (row_at + 1 < h) begin
            made[made_n].run_x      = RUN_XY_W'(col);
            made[made_n].run_y      = RUN_XY_W'(row_at);
            made[made_n].run_length = DIM_W'(len);
            made[made_n].clut_index = cfg_palette[4*colour +: 4];
            made[made_n].run_alpha  = see_through[colour] ? '0 : cfg_alpha[8*colour +: 8];
            made[made_n].run_last   = 1'b0;
            made_n++;
         end
         col += len;
         code = '0;
         held = 0;
         if (col >= w) begin
            col = 0;
            row_at += 2;
            if (half == 0) skip_low = 1'b1;
            if (row_at >= h) row_at = (row_at + 1) % h;
         end
      end
      if (pos < POS_MAX) pos++;
      if (last) restart_packet();
      if (made_n > 0) made[made_n-1].run_last = 1'b1;
      if (publish) begin
         for (int i = 0; i < made_n; i++) expected_runs.push_back(made[i]);
      end
   endtask

   function automatic run_type run_of(int x, int y, int len, int clut, int alpha, bit last);
      run_type r;
      r.run_x      = RUN_XY_W'(x);
      r.run_y      = RUN_XY_W'(y);
      r.run_length = DIM_W'(len);
      r.clut_index = CLUT_W'(clut);
      r.run_alpha  = ALPHA_W'(alpha);
      r.run_last   = last;
      return r;
   endfunction

   function automatic plan_step_type byte_step(logic [BYTE_W-1:0] data, logic first,
                                               logic last);
      plan_step_type s;
      s = '0;
      s.kind  = STEP_BYTE;
      s.data  = data;
      s.first = first;
      s.last  = last;
      return s;
   endfunction

   function automatic plan_step_type typed_step(logic [BYTE_W-1:0] data, logic first,
                                                logic last, logic [1:0] n,
                                                run_type run_a, run_type run_b);
      plan_step_type s;
      s = byte_step(data, first, last);
      s.typed  = 1'b1;
      s.n_runs = n;
      s.run_a  = run_a;
      s.run_b  = run_b;
      return s;
   endfunction

   function automatic plan_step_type csr_step(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      plan_step_type s;
      s = '0;
      s.kind      = STEP_CSR;
      s.csr_idx   = idx;
      s.csr_value = value;
      return s;
   endfunction

   function automatic logic [3:0] random_nibble();
      return ($urandom_range(99) < 35) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
   endfunction

   function automatic plan_step_type random_byte(logic first, logic last);
      return byte_step({random_nibble(), random_nibble()}, first, last);
   endfunction

   function automatic string describe_run(run_type r);
      return $sformatf("x=%0d y=%0d len=%0d clut=%0d alpha=%0d last=%0d",
                       r.run_x, r.run_y, r.run_length, r.clut_index, r.run_alpha, r.run_last);
   endfunction

   task automatic send_byte(input plan_step_type s);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= s.data;
      req_bus.first_byte <= s.first;
      req_bus.last_byte  <= s.last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_accepted++;
      decode_pixel_byte(s.data, s.first, s.last, !s.typed);
      if (s.typed) begin
         if (s.n_runs > 0) expected_runs.push_back(s.run_a);
         if (s.n_runs > 1) expected_runs.push_back(s.run_b);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_register(idx, value);
   endtask

   always @(posedge clock) begin : check_runs
      run_type got;
      run_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.run_x, rsp_bus.run_y, rsp_bus.run_length, rsp_bus.clut_index,
                rsp_bus.run_alpha, rsp_bus.run_last};
         if (expected_runs.size() == 0) begin
            failures++;
            $display("%0t: run transfer, expected none, actual %s", $time, describe_run(got));
         end else begin
            want = expected_runs.pop_front();
            if (want.run_x !== got.run_x || want.run_y !== got.run_y ||
                want.run_length !== got.run_length || want.clut_index !== got.clut_index ||
                want.run_alpha !== got.run_alpha || want.run_last !== got.run_last) begin
               failures++;
               $display("%0t: run transfer, expected %s, actual %s", $time,
                        describe_run(want), describe_run(got));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("subpicture_rle_run_decoder: mismatch");
         $finish;
      end
   end

   initial begin : run_sink
      int hold_left;
      bit pressure_done;
      hold_left = 0;
      pressure_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!pressure_done && bytes_accepted >= HOLD_AFTER) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   initial begin : stimulus
      plan_step_type    plan[$];
      logic [CSR_W-1:0] w;
      logic [CSR_W-1:0] h;
      logic [CSR_W-1:0] o;
      logic [CSR_W-1:0] pal;
      logic [CSR_W-1:0] a;
      int               n;
      int               sent;
      req_bus.valid      <= 1'b0;
      req_bus.data_byte  <= '0;
      req_bus.first_byte <= 1'b0;
      req_bus.last_byte  <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_WIDTH;
      csr_wdata          <= '0;
      restart_packet();

      plan.push_back(typed_step(8'h00, 1'b1, 1'b0, 2'd0, '0, '0));
      plan.push_back(typed_step(8'h00, 1'b0, 1'b0, 2'd1, run_of(0, 0, 720, 0, 0, 1'b1), '0));
      plan.push_back(typed_step(8'hFF, 1'b0, 1'b0, 2'd2, run_of(0, 2, 3, 3, 255, 1'b0),
                                run_of(3, 2, 3, 3, 255, 1'b1)));
      plan.push_back(byte_step(8'h12, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h05, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h6A, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h00, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h3C, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h40, 1'b0, 1'b1));
      plan.push_back(byte_step(8'h00, 1'b1, 1'b0));
      plan.push_back(byte_step(8'h01, 1'b0, 1'b1));
      plan.push_back(csr_step(CSR_WIDTH, 16));
      plan.push_back(csr_step(CSR_HEIGHT, 4));
      plan.push_back(byte_step(8'h00, 1'b1, 1'b0));
      plan.push_back(byte_step(8'h00, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h44, 1'b0, 1'b0));
      plan.push_back(csr_step(CSR_WIDTH, 1));
      plan.push_back(byte_step(8'h48, 1'b0, 1'b0));
      plan.push_back(byte_step(8'hFF, 1'b0, 1'b0));
      plan.push_back(byte_step(8'hFF, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h7F, 1'b0, 1'b1));
      plan.push_back(csr_step(CSR_WIDTH, 64));
      plan.push_back(csr_step(CSR_FIELD_START, 6));
      plan.push_back(byte_step(8'h44, 1'b1, 1'b0));
      plan.push_back(byte_step(8'h41, 1'b0, 1'b0));
      plan.push_back(byte_step(8'hF5, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h88, 1'b0, 1'b0));
      plan.push_back(byte_step(8'h00, 1'b0, 1'b1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR) begin
            settle();
            write_register(plan[i].csr_idx, plan[i].csr_value);
            csr_we <= 1'b0;
         end else begin
            send_byte(plan[i]);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         w = $urandom;
         h = $urandom;
         o = $urandom;
         pal = $urandom;
         a = $urandom;
         w[DIM_W-1:0] = DIM_W'($urandom_range(1, 48));
         h[DIM_W-1:0] = DIM_W'($urandom_range(1, 16));
         o[POS_W-1:0] = POS_W'($urandom_range(0, 50));
         case (p)
            0: begin
               w[DIM_W-1:0] = '0;
               h[DIM_W-1:0] = '1;
               o[POS_W-1:0] = '0;
               pal[15:0] = '0;
               a = '0;
            end
            1: begin
               w[DIM_W-1:0] = '1;
               h[DIM_W-1:0] = '0;
               o[POS_W-1:0] = '1;
               pal[15:0] = '1;
               a = '1;
            end
            2: begin
               w[DIM_W-1:0] = DIM_W'(MAX_DIM);
               h[DIM_W-1:0] = DIM_W'(MAX_DIM);
            end
            3: begin
               w[DIM_W-1:0] = DIM_W'(1);
               h[DIM_W-1:0] = DIM_W'(2);
            end
            default: ;
         endcase
         settle();
         write_register(CSR_WIDTH, w);
         write_register(CSR_FIELD_START, o);
         write_register(CSR_PALETTE, pal);
         write_register(CSR_ALPHA, a);
         write_register(CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1, CSR_COUNT)), $urandom);
         write_register(CSR_HEIGHT, h);
         csr_we <= 1'b0;
         calm = (p == 5);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
               send_byte(random_byte(i == 0 || $urandom_range(99) < 3,
                                     (i == n - 1) ? $urandom_range(99) >= 5
                                                  : $urandom_range(99) < 3));
            sent += n;
         end
      end

      // start the odd field well into a full-size packet
      calm = 1'b0;
      settle();
      write_register(CSR_WIDTH, MAX_DIM);
      write_register(CSR_FIELD_START, LONG_FIELD);
      write_register(CSR_PALETTE, $urandom);
      write_register(CSR_ALPHA, $urandom);
      write_register(CSR_HEIGHT, MAX_DIM);
      csr_we <= 1'b0;
      for (int i = 0; i < LONG_BYTES; i++)
         send_byte(random_byte(i == 0, i == LONG_BYTES - 1));

      settle();
      if (failures == 0) begin
         $display("subpicture_rle_run_decoder: match");
      end else begin
         $display("subpicture_rle_run_decoder: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/rlerd_pkg.sv
hdl/rlerd_ifs.sv
hdl/rlerd_csr.sv
hdl/rlerd_rowmod.sv
hdl/rlerd_decode.sv
hdl/rlerd_outq.sv
hdl/subpicture_rle_run_decoder.sv
test/tb.sv
